// ===== rtl/hce_pkg.sv =====
// shared types and constants for the chunked transfer encoder
// no dependencies
package hce_pkg;

  // fixed field and counter widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CntW      = 6;
  localparam int unsigned ChunkDflt = 32;

  // request codes
  localparam logic ReqPush   = 1'b0;
  localparam logic ReqFinish = 1'b1;

  // framing characters
  localparam logic [ByteW-1:0] ChCr   = 8'h0d;
  localparam logic [ByteW-1:0] ChLf   = 8'h0a;
  localparam logic [ByteW-1:0] ChZero = 8'h30;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] body_byte;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
  } out_t;

  // lowercase hex digit for one nibble
  function automatic logic [ByteW-1:0] hex_char(logic [3:0] nib);
    logic [ByteW-1:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return ChZero + ext;
    end else begin
      return 8'h57 + ext;
    end
  endfunction

endpackage

// ===== rtl/http_chunked_encoder_core.sv =====
// chunked transfer encoder top level: chunk buffer memory, emit sequencer, output register
// depends on hce_pkg
//
// Body bytes are stored one per cycle while in_ready_o is high into a CHUNK_BYTES deep buffer
// memory; a push that finds the buffer not full is stored directly and produces no word. A
// push that finds it full, and a finish that finds bytes pending, replay the chunk: hex length
// (one or two digits), CR LF, the buffered bytes, CR LF, one output word per cycle while the
// sink is ready. The buffer has a single synchronous read port, so the replay is paced at one
// byte per cycle by that port. A finish then adds "0" CR LF CR LF (five words). A chunk of N
// bytes is thus sent as N + 5 or N + 6 words. in_ready_o is high only while the sequencer is
// idle, with no replay or trailer in progress; a finished word may still wait in the output
// register. last_of_run marks the final word of each item.
module http_chunked_encoder_core #(
  parameter int unsigned CHUNK_BYTES = hce_pkg::ChunkDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hce_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hce_pkg::out_t out_data_o
);
  import hce_pkg::*;

  // buffer index width; at least one bit even for a single entry buffer
  localparam int unsigned IdxW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [CntW-1:0] ChunkCnt = CntW'(CHUNK_BYTES);

  // one-hot sequencer states
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0_0000_0000_0001,
    S_HEX_HI = 13'b0_0000_0000_0010,
    S_HEX_LO = 13'b0_0000_0000_0100,
    S_CR1    = 13'b0_0000_0000_1000,
    S_LF1    = 13'b0_0000_0001_0000,
    S_DATA   = 13'b0_0000_0010_0000,
    S_CR2    = 13'b0_0000_0100_0000,
    S_LF2    = 13'b0_0000_1000_0000,
    S_T0     = 13'b0_0001_0000_0000,
    S_TCR1   = 13'b0_0010_0000_0000,
    S_TLF1   = 13'b0_0100_0000_0000,
    S_TCR2   = 13'b0_1000_0000_0000,
    S_TLF2   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]  fill_q, fill_d;     // bytes held in the buffer
  logic [CntW-1:0]  idx_q, idx_d;       // replay position
  logic             fin_q, fin_d;       // current item is a finish
  logic [ByteW-1:0] held_q, held_d;     // push byte that waits for the replay to end

  // output register
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  // buffer memory, one write and one registered read port
  logic [ByteW-1:0] chunk_mem_q [CHUNK_BYTES];
  logic [ByteW-1:0] rd_data_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_wa, mem_ra;
  logic [ByteW-1:0] mem_wd;

  logic             in_acc;
  logic             step;     // one word moves into the output register
  logic             emit_st;  // sequencer sits in a word-producing state
  logic             full;
  logic [CntW-1:0]  idx_nxt;
  logic [ByteW-1:0] word_byte;
  logic             word_last;

  assign full       = (fill_q >= ChunkCnt);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit_st    = (state_q != S_IDLE);
  // a word may enter when the output register is empty or drains this cycle
  assign step       = emit_st && (!out_valid_q || out_ready_i);
  assign idx_nxt    = idx_q + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chunk_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= chunk_mem_q[mem_ra];
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    held_d      = held_q;
    mem_we      = 1'b0;
    mem_wa      = fill_q[IdxW-1:0];
    mem_wd      = in_data_i.body_byte;
    mem_re      = 1'b0;
    mem_ra      = '0;
    word_byte   = ChZero;
    word_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == ReqPush) begin
            if (!full) begin
              // plain store, no output
              mem_we = 1'b1;
              fill_d = fill_q + CntW'(1);
            end else begin
              // replay first, store the byte at the end
              fin_d   = 1'b0;
              held_d  = in_data_i.body_byte;
              state_d = (fill_q[5:4] != 2'b00) ? S_HEX_HI : S_HEX_LO;
            end
          end else begin
            fin_d = 1'b1;
            if (fill_q != '0) begin
              state_d = (fill_q[5:4] != 2'b00) ? S_HEX_HI : S_HEX_LO;
            end else begin
              state_d = S_T0;
            end
          end
        end
      end
      S_HEX_HI: begin
        word_byte = hex_char({2'b00, fill_q[5:4]});
        if (step) state_d = S_HEX_LO;
      end
      S_HEX_LO: begin
        word_byte = hex_char(fill_q[3:0]);
        if (step) state_d = S_CR1;
      end
      S_CR1: begin
        word_byte = ChCr;
        if (step) state_d = S_LF1;
      end
      S_LF1: begin
        word_byte = ChLf;
        if (step) begin
          // fetch the first buffered byte
          mem_re  = 1'b1;
          mem_ra  = '0;
          idx_d   = '0;
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        word_byte = rd_data_q;
        if (step) begin
          if (idx_nxt == fill_q) begin
            state_d = S_CR2;
          end else begin
            // read is only issued on advance, so rd_data_q holds across stalls
            mem_re = 1'b1;
            mem_ra = idx_nxt[IdxW-1:0];
            idx_d  = idx_nxt;
          end
        end
      end
      S_CR2: begin
        word_byte = ChCr;
        if (step) state_d = S_LF2;
      end
      S_LF2: begin
        word_byte = ChLf;
        word_last = !fin_q;
        if (step) begin
          if (fin_q) begin
            state_d = S_T0;
          end else begin
            // held push byte opens the next chunk
            mem_we  = 1'b1;
            mem_wa  = '0;
            mem_wd  = held_q;
            fill_d  = CntW'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_T0: begin
        word_byte = ChZero;
        if (step) state_d = S_TCR1;
      end
      S_TCR1: begin
        word_byte = ChCr;
        if (step) state_d = S_TLF1;
      end
      S_TLF1: begin
        word_byte = ChLf;
        if (step) state_d = S_TCR2;
      end
      S_TCR2: begin
        word_byte = ChCr;
        if (step) state_d = S_TLF2;
      end
      S_TLF2: begin
        word_byte = ChLf;
        word_last = 1'b1;
        if (step) begin
          fill_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register load and drain
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = word_byte;
      out_d.last_of_run = word_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // buffer never holds more than one chunk
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ChunkCnt)
    else $error("fill count beyond chunk size");

  // replay only runs over a non-empty buffer and stays below the fill count
  a_data_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (fill_q != '0) && (idx_q < fill_q))
    else $error("replay index out of range");

  // buffer port never reads and writes in the same cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("buffer read and write overlap");

  // a word is only loaded when the output register has room
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("output word overwritten while stalled");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for http_chunked_encoder_core: random and directed push/finish words
// depends on hce_pkg and the core rtl; predicts the chunked byte stream on its own
module tb_top;

  import hce_pkg::*;

  localparam int unsigned ChunkLen    = ChunkDflt;
  localparam int unsigned RandTarget  = 180;
  localparam int unsigned LongHoldLen = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned MaxReports  = 10;

  // one pending input word, optionally held back until the output side has drained
  typedef struct {
    in_t word;
    bit  wait_drain;
  } pend_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // handshake seen at the last rising edge, consumed at the next falling edge
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  pend_t pend_q[$];
  out_t  enc_bytes_q[$];

  // predictor state
  logic [ByteW-1:0] chunk_mem[ChunkLen];
  int unsigned      chunk_fill = 0;

  int unsigned words_in     = 0;
  int unsigned words_out    = 0;
  int unsigned n_err        = 0;
  int unsigned full_flushes = 0;
  int unsigned finishes     = 0;
  int unsigned max_runs     = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_at      = 0;

  http_chunked_encoder_core #(
    .CHUNK_BYTES(ChunkLen)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [ByteW-1:0] hex_digit(int unsigned v);
    if (v < 10) begin
      return ChZero + 8'(v);
    end else begin
      return 8'h61 + 8'(v - 10);
    end
  endfunction

  function automatic void push_enc(logic [ByteW-1:0] b);
    out_t w;
    w.out_byte    = b;
    w.last_of_run = 1'b0;
    enc_bytes_q.push_back(w);
  endfunction

  // length in hex without leading zeros, crlf, buffered bytes, crlf
  function automatic void queue_chunk();
    if (chunk_fill >= 16) begin
      push_enc(hex_digit(chunk_fill >> 4));
    end
    push_enc(hex_digit(chunk_fill & 15));
    push_enc(ChCr);
    push_enc(ChLf);
    for (int unsigned i = 0; i < chunk_fill; i++) begin
      push_enc(chunk_mem[i]);
    end
    push_enc(ChCr);
    push_enc(ChLf);
  endfunction

  function automatic void encode_word(in_t w);
    int unsigned start;
    start = enc_bytes_q.size();
    if (w.req_type == ReqPush) begin
      // a full buffer is flushed before the new byte goes in
      if (chunk_fill >= ChunkLen) begin
        queue_chunk();
        chunk_fill = 0;
        full_flushes++;
      end
      chunk_mem[chunk_fill] = w.body_byte;
      chunk_fill++;
    end else begin
      if (chunk_fill == ChunkLen) begin
        max_runs++;
      end
      if (chunk_fill != 0) begin
        queue_chunk();
      end
      push_enc(ChZero);
      push_enc(ChCr);
      push_enc(ChLf);
      push_enc(ChCr);
      push_enc(ChLf);
      chunk_fill = 0;
      finishes++;
    end
    // mark the final byte of this word's run
    if (enc_bytes_q.size() > start) begin
      enc_bytes_q[enc_bytes_q.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_word(logic req, logic [ByteW-1:0] b, bit drain);
    pend_t p;
    p.word.req_type  = req;
    p.word.body_byte = b;
    p.wait_drain     = drain;
    pend_q.push_back(p);
  endfunction

  function automatic int unsigned draw_gap(ref bit burst);
    // occasionally flip between back-to-back and randomly gapped traffic
    if ($urandom_range(0, 7) == 0) begin
      burst = !burst;
    end
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued words at the falling edge
  // ---------------------------------------------------------------------------

  int unsigned send_gap   = 0;
  bit          send_burst = 1'b0;

  always @(negedge clk) begin : sender
    pend_t nx;
    if (rst_n) begin
      // free to change only when nothing is offered or the last word was taken
      if (!in_valid || in_took) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pend_q.size() != 0 &&
                     !(pend_q[0].wait_drain && enc_bytes_q.size() != 0)) begin
          nx = pend_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= nx.word;
          send_gap = draw_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready per word plus one long hold-off
  // ---------------------------------------------------------------------------

  int unsigned recv_gap       = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          recv_burst     = 1'b0;

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      // long stall while the sender keeps pushing, so the core backs up its input
      if (!long_hold_done && hold_at != 0 && words_in >= hold_at) begin
        long_hold_left = LongHoldLen;
        long_hold_done = 1'b1;
      end
      if (out_took) begin
        recv_gap = draw_gap(recv_burst);
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both handshakes at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    out_t want;
    out_t got;
    if (rst_n) begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        got = out_data;
        if (enc_bytes_q.size() == 0) begin
          n_err++;
          if (n_err <= MaxReports) begin
            $display("unexpected word %0d: byte %02h last %0b",
                     words_out, got.out_byte, got.last_of_run);
          end
        end else begin
          want = enc_bytes_q.pop_front();
          if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
            n_err++;
            if (n_err <= MaxReports) begin
              $display("mismatch at word %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       words_out, want.out_byte, want.last_of_run,
                       got.out_byte, got.last_of_run);
            end
          end
        end
        words_out++;
      end
      // the output is registered, so a word taken now cannot answer at this edge
      if (in_valid && in_ready) begin
        encode_word(in_data);
        words_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no handshake on either side
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, enc_bytes_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned rand_words;
    int unsigned len;
    int unsigned kind;
    bit          drain;
    bit          do_finish;

    // directed: empty finish twice, short chunk with extreme bytes, single byte, three-byte chunk
    add_word(ReqFinish, 8'h00, 1'b0);
    add_word(ReqFinish, 8'hff, 1'b0);
    add_word(ReqPush,   8'h00, 1'b0);
    add_word(ReqPush,   8'hff, 1'b0);
    add_word(ReqPush,   8'haa, 1'b0);
    add_word(ReqPush,   8'h55, 1'b0);
    add_word(ReqFinish, 8'h5a, 1'b0);
    add_word(ReqPush,   8'h80, 1'b0);
    add_word(ReqFinish, 8'h01, 1'b0);
    add_word(ReqPush,   8'h7f, 1'b0);
    add_word(ReqPush,   8'h01, 1'b0);
    add_word(ReqPush,   8'hfe, 1'b0);
    add_word(ReqFinish, 8'h00, 1'b0);
    hold_at = pend_q.size() + 30;

    // random streams: empty, short, exactly full, near full, overflowing, and open-ended runs
    rand_words = 0;
    drain      = 1'b1;
    while (rand_words < RandTarget) begin
      kind      = $urandom_range(0, 9);
      do_finish = 1'b1;
      case (kind)
        0: begin
          len = 0;
        end
        1, 2, 3, 4: begin
          len = $urandom_range(1, 20);
        end
        5: begin
          len = ChunkLen;
        end
        6: begin
          len = $urandom_range(ChunkLen - 2, ChunkLen + 2);
        end
        7, 8: begin
          len = $urandom_range(ChunkLen + 1, 3 * ChunkLen);
        end
        default: begin
          len       = $urandom_range(1, 12);
          do_finish = 1'b0;
        end
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        add_word(ReqPush, 8'($urandom_range(0, 255)), drain && i == 0);
        rand_words++;
      end
      if (do_finish) begin
        add_word(ReqFinish, 8'($urandom_range(0, 255)), drain && len == 0);
        rand_words++;
      end
      // every so often the sender waits for the output side to drain
      drain = ($urandom_range(0, 9) == 0);
    end
    // close the stream so nothing is left buffered
    add_word(ReqFinish, 8'($urandom_range(0, 255)), 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (enc_bytes_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("run: %0d words in, %0d bytes out, %0d finishes, %0d full-buffer flushes",
             words_in, words_out, finishes, full_flushes);
    $display("run: %0d finishes with a full chunk, %0d mismatches", max_runs, n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
